// ----- design/double_ended_queue_macros.svh -----
// ---------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared property templates for the port checker of the deque.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Condition a implies condition c in the same cycle, outside reset.
`define DEQ_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("deque port check failed");

// Condition a implies condition c in the following cycle, outside reset.
`define DEQ_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("deque port check failed");

`endif

// ----- design/deq_pkg.sv -----
// ---------------------------------------------------------------------------
// Deque package
// Command and status codes, control states and the queued command item.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W = 32;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SHOW       = 3'd4
  } deq_cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } deq_state_t;

  typedef struct packed {
    deq_cmd_t                  cmd;
    logic signed [DATA_W-1:0]  value;
  } deq_item_t;

endpackage

// ----- design/double_ended_queue.sv -----
// A push, a refused push or an empty result is registered in the command queue and then in the output register.
// A pop is registered in the command queue, then at the registered read port of the store, then in the output register.
// Show takes the same path as a pop, then gives 2 * count results, one per cycle while the output is not stalled.
// The back end takes no new command while a pop or a show is still giving its results.
// A two-item command queue lets input be taken while results wait on the output register.
// Synchronous active-low reset clears the front index, the count and all handshake state.
// ---------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values held as a ring in a local store.
// ---------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd [2:0], value [34:3], zero fill [39:35]
  input  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // data_out [31:0]
  output logic [deq_pkg::DATA_W-1:0]      out_tdata,
  // status [1:0], backward_pass [2]
  output logic [deq_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import deq_pkg::*;

  logic      q_valid;
  logic      q_ready;
  deq_item_t q_item;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- design/deq_front.sv -----
// ---------------------------------------------------------------------------
// Deque front end
// Accepts commands, drops unused codes and holds up to two in a queue.
// ---------------------------------------------------------------------------
module deq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                         q_valid,
  input  logic                         q_ready,
  output deq_pkg::deq_item_t           q_item
);
  import deq_pkg::*;

  deq_item_t  buf_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       code_ok;
  logic       push;
  logic       pop;

  always_comb begin
    code_ok = (in_tdata[2:0] == CMD_PUSH_FRONT) || (in_tdata[2:0] == CMD_PUSH_BACK) ||
              (in_tdata[2:0] == CMD_POP_FRONT) || (in_tdata[2:0] == CMD_POP_BACK) ||
              (in_tdata[2:0] == CMD_SHOW);
    in_tready  = (cnt_r != 2'd2);
    q_valid    = (cnt_r != 2'd0);
    q_item     = buf_r[rd_ptr_r];
    push       = in_tvalid && in_tready && code_ok;
    pop        = q_valid && q_ready;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r].cmd   <= deq_cmd_t'(in_tdata[2:0]);
      buf_r[wr_ptr_r].value <= in_tdata[34:3];
    end
  end

endmodule

// ----- design/deq_back.sv -----
// ---------------------------------------------------------------------------
// Deque back end
// Executes commands on the ring store and drives the registered result.
// ---------------------------------------------------------------------------
module deq_back #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  deq_pkg::deq_item_t            q_item,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [deq_pkg::DATA_W-1:0]    out_tdata,
  output logic [deq_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                          out_tlast
);
  import deq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  deq_state_t        state_r, state_nxt;
  logic [IW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              bwd_r, bwd_nxt;
  logic              show_r, show_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_bwd_r;
  logic              out_last_r;

  logic              slot_free;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              ld;
  logic [1:0]        ld_status;
  logic [DATA_W-1:0] ld_data;
  logic              ld_bwd;
  logic              ld_last;

  always_comb begin
    slot_free = !out_valid_r || out_tready;
    full      = (count_r == CW'(DEPTH));
    empty     = (count_r == '0);
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    bwd_nxt   = bwd_r;
    show_nxt  = show_r;
    q_ready   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    ld        = 1'b0;
    ld_status = ST_OK;
    ld_data   = '0;
    ld_bwd    = 1'b0;
    ld_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        q_ready = slot_free;
        if (q_valid && slot_free) begin
          case (q_item.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
                if (q_item.cmd == CMD_PUSH_FRONT) begin
                  wr_addr   = ring(front_r, CW'(DEPTH - 1));
                  front_nxt = ring(front_r, CW'(DEPTH - 1));
                end else begin
                  wr_addr = ring(front_r, count_r);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                count_nxt = count_r - CW'(1);
                show_nxt  = 1'b0;
                state_nxt = S_EMIT;
                if (q_item.cmd == CMD_POP_FRONT) begin
                  rd_addr   = front_r;
                  front_nxt = ring(front_r, CW'(1));
                end else begin
                  rd_addr = ring(front_r, count_r - CW'(1));
                end
              end
            end
            CMD_SHOW: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                pos_nxt   = '0;
                bwd_nxt   = 1'b0;
                show_nxt  = 1'b1;
                state_nxt = S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ld      = 1'b1;
          ld_data = rd_data_r;
          ld_bwd  = show_r && bwd_r;
          ld_last = !show_r || (bwd_r && (pos_r == '0));
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en = 1'b1;
            if (!bwd_r) begin
              if (pos_r == count_r - CW'(1)) begin
                bwd_nxt = 1'b1;
                rd_addr = ring(front_r, pos_r);
              end else begin
                pos_nxt = pos_r + CW'(1);
                rd_addr = ring(front_r, pos_r + CW'(1));
              end
            end else begin
              pos_nxt = pos_r - CW'(1);
              rd_addr = ring(front_r, pos_r - CW'(1));
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      bwd_r       <= 1'b0;
      show_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      bwd_r   <= bwd_nxt;
      show_r  <= show_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_bwd_r    <= ld_bwd;
      out_last_r   <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_item.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_bwd_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- design/deq_checker.sv -----
// ---------------------------------------------------------------------------
// Deque port checker
// Checks the result channel of the deque as seen on its ports.
// ---------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [deq_pkg::DATA_W-1:0]      out_tdata,
  input logic [deq_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import deq_pkg::*;

  logic [1:0] out_status;
  logic       out_bwd;
  logic       out_stall;
  logic       status_known;
  logic       fail_item;
  logic       fail_shape;
  logic       bwd_more;
  logic       bwd_next;

  assign out_status   = out_tuser[1:0];
  assign out_bwd      = out_tuser[2];
  assign out_stall    = out_tvalid && !out_tready;
  assign status_known = (out_status == ST_OK) || (out_status == ST_FULL) ||
                        (out_status == ST_EMPTY);
  assign fail_item    = out_tvalid && (out_status != ST_OK);
  assign fail_shape   = out_tlast && (out_tdata == '0) && !out_bwd;
  assign bwd_more     = out_tvalid && out_tready && out_bwd && !out_tlast;
  assign bwd_next     = out_tvalid && out_bwd && (out_status == ST_OK);

  `DEQ_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable({out_tdata, out_tuser, out_tlast}))
  `DEQ_ASSERT_SAME(a_status_code, out_tvalid, status_known)
  `DEQ_ASSERT_SAME(a_fail_single, fail_item, fail_shape)
  `DEQ_ASSERT_NEXT(a_back_pass, bwd_more, bwd_next)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

// ----- sim/double_ended_queue_test.sv -----
// ---------------------------------------------------------------------------
// Double-ended queue regression
// Streams push, pop and show commands into the deque and checks every result
// against a behavioral copy of the ring. A directed table covers the empty
// corners, wrap of the front index and the unused command codes. It is
// followed by random fill and drain runs under three sender and receiver idle
// mixes, which also reach the full corner.
// ---------------------------------------------------------------------------
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS = 225;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] data;
    logic        back;
    logic        last;
  } deq_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    bit          typed;
    logic [1:0]  status;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [DATA_W-1:0]       out_tdata;
  logic [OUT_TUSER_W-1:0]  out_tuser;
  logic                    out_tlast;

  logic [31:0]  ring_store [DEPTH];
  int           ring_front = 0;
  int           ring_count = 0;
  deq_result_t  awaited_results [$];
  int           error_count = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           filling = 1'b1;

  // Typed rows carry their single result directly; the rest use the ring copy.
  stim_row_t directed_rows [25] = '{
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_SHOW,       32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_RSVD_5,     32'hFFFF_FFFF, 1'b0, ST_OK},
    '{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'h8000_0000, 1'b1, ST_OK},
    '{CMD_SHOW,       32'h0000_0000, 1'b0, ST_OK},
    '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK},
    '{CMD_PUSH_FRONT, 32'hA5A5_A5A5, 1'b1, ST_OK},
    '{CMD_PUSH_BACK,  32'h5A5A_5A5A, 1'b1, ST_OK},
    '{CMD_SHOW,       32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'hFFFF_FFFF, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'hFFFF_FFFF, 1'b0, ST_OK},
    '{CMD_RSVD_6,     32'hFFFF_FFFF, 1'b0, ST_OK},
    '{CMD_RSVD_7,     32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b0, ST_OK},
    '{CMD_SHOW,       32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_PUSH_BACK,  32'h0000_0001, 1'b1, ST_OK},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK},
    '{CMD_SHOW,       32'h0000_0000, 1'b1, ST_EMPTY}
  };

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic step_ring(input logic [2:0] cmd, input logic [31:0] value,
                           output deq_result_t res [$]);
    deq_result_t r;
    int k;
    res = {};
    r = '{ST_OK, 32'd0, 1'b0, 1'b1};
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            ring_store[ring_front] = value;
          end else begin
            ring_store[(ring_front + ring_count) % DEPTH] = value;
          end
          ring_count++;
        end
        res.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            r.data = ring_store[ring_front];
            ring_front = (ring_front + 1) % DEPTH;
          end else begin
            r.data = ring_store[(ring_front + ring_count - 1) % DEPTH];
          end
          ring_count--;
        end
        res.push_back(r);
      end
      CMD_SHOW: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
          res.push_back(r);
        end else begin
          for (k = 0; k < ring_count; k++) begin
            res.push_back('{ST_OK, ring_store[(ring_front + k) % DEPTH], 1'b0, 1'b0});
          end
          for (k = ring_count; k > 0; k--) begin
            res.push_back('{ST_OK, ring_store[(ring_front + k - 1) % DEPTH], 1'b1,
                            (k == 1)});
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_command(input logic [2:0] cmd, input logic [31:0] value,
                              input bit typed, input logic [1:0] typed_status);
    deq_result_t res [$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, value, cmd};
    do @(posedge clk); while (!in_tready);
    step_ring(cmd, value, res);
    if (typed) begin
      awaited_results.push_back('{typed_status, 32'd0, 1'b0, 1'b1});
    end else begin
      foreach (res[i]) awaited_results.push_back(res[i]);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("item with no result awaited: data_out %h", out_tdata);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser[1:0]);
          error_count++;
        end
        if (out_tdata !== want.data) begin
          $error("data_out: expected %h, actual %h", want.data, out_tdata);
          error_count++;
        end
        if (out_tuser[2] !== want.back) begin
          $error("backward_pass: expected %0d, actual %0d", want.back, out_tuser[2]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("double_ended_queue regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0]  cmd;
    logic [31:0] value;
    int          roll;
    int          sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 53;
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].status);
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 36 : 0;
      sent = 0;
      while (sent < (RANDOM_ITEMS + 2) / 3) begin
        // Runs fill up to full and drain down to empty, lingering at each end.
        if (ring_count == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        if (ring_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
        roll = $urandom_range(99);
        if (roll < 4) begin
          cmd = 3'($urandom_range(CMD_RSVD_7, CMD_RSVD_5));
        end else if (roll < 12) begin
          cmd = CMD_SHOW;
        end else if ((roll < 70) == filling) begin
          cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else begin
          cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        value = $urandom();
        send_command(cmd, value, 1'b0, ST_OK);
        if (cmd <= CMD_SHOW) sent++;
      end
    end
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
+incdir+design
design/deq_pkg.sv
design/deq_front.sv
design/deq_back.sv
design/double_ended_queue.sv
design/deq_checker.sv
sim/double_ended_queue_test.sv
